[rtl/core/prefix_trie_counter_assert.svh]
// assertion macros for the checker of the trie counter
`ifndef PREFIX_TRIE_COUNTER_ASSERT_SVH
`define PREFIX_TRIE_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define PTC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/ptc_pkg.sv]
package ptc_pkg;

   localparam int MAX_NODES_DEF   = 1024;
   localparam int ALPHABET_DEF    = 26;
   localparam int MAX_LEN_DEF     = 32;
   localparam int COUNT_WIDTH_DEF = 16;

   localparam logic [15:0] OUT_COUNT_MAX = 16'hFFFF;

   localparam logic [2:0] CMD_ADD          = 3'd0;
   localparam logic [2:0] CMD_EXISTS       = 3'd1;
   localparam logic [2:0] CMD_COUNT_EXACT  = 3'd2;
   localparam logic [2:0] CMD_COUNT_PREFIX = 3'd3;
   localparam logic [2:0] CMD_REMOVE       = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   typedef struct packed {
      logic [2:0] cmd;
      logic [4:0] symbol;
      logic       has_symbol;
      logic       last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] count;
      logic [1:0]  status;
   } rsp_type;

endpackage

[rtl/core/prefix_trie_counter.sv]
// sequence: a letter item that walks is accepted in S_IDLE, then S_WALK does the
// child-table read and node update; any other item without the last mark is taken in
// S_IDLE alone. a last item adds S_LEXEC for the count read and its result shows on
// rsp_valid in the cycle after that; a remove that succeeds adds S_POP_CNT and S_POP_WR
// per stacked node first. a request is taken only in S_IDLE. here the receiver cannot
// stall. after reset busy stays high while the child table and counts are cleared.
module prefix_trie_counter #(
   parameter int MAX_NODES   = ptc_pkg::MAX_NODES_DEF,
   parameter int ALPHABET    = ptc_pkg::ALPHABET_DEF,
   parameter int MAX_LEN     = ptc_pkg::MAX_LEN_DEF,
   parameter int COUNT_WIDTH = ptc_pkg::COUNT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ptc_pkg::req_type req_item,
   output logic             rsp_valid,
   output ptc_pkg::rsp_type rsp_item
);

   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int USED_W      = $clog2(MAX_NODES + 1);
   localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
   localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
   localparam int DEPTH_W     = $clog2(MAX_LEN + 2);
   localparam int STACK_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW          = COUNT_WIDTH;

   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_WALK    = 3'd2;
   localparam logic [2:0] S_LEXEC   = 3'd3;
   localparam logic [2:0] S_POP_CNT = 3'd4;
   localparam logic [2:0] S_POP_WR  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CHILD_AW-1:0] clear_ff, clear_in;
   ptc_pkg::req_type    req_ff, req_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic                miss_ff, miss_in;
   logic [DEPTH_W-1:0]  pop_ff, pop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ptc_pkg::rsp_type    rsp_ff, rsp_in;

   logic                child_wr_en;
   logic [CHILD_AW-1:0] child_wr_addr;
   logic [NODE_W-1:0]   child_wr_data;
   logic [CHILD_AW-1:0] child_rd_addr;
   logic [NODE_W-1:0]   child_rd_data;

   logic                cnt_wr_en;
   logic [NODE_W-1:0]   cnt_wr_addr;
   logic [2*CW-1:0]     cnt_wr_data;
   logic [NODE_W-1:0]   cnt_rd_addr;
   logic [2*CW-1:0]     cnt_rd_data;

   logic                stack_wr_en;
   logic [STACK_AW-1:0] stack_wr_addr;
   logic [NODE_W-1:0]   stack_rd_data;

   logic [4:0]          sym_sel;
   logic [CHILD_AW-1:0] slot;
   logic                in_range;
   logic                walk;
   logic [CW-1:0]       cnt_end;
   logic [CW-1:0]       cnt_pass;
   logic [CW-1:0]       end_inc;
   logic [CW-1:0]       end_dec;
   logic [CW-1:0]       pass_inc;
   logic [CW-1:0]       pass_dec;
   logic [CW-1:0]       count_sel;
   logic [15:0]         count_sat;
   logic                pool_full;
   logic [NODE_W-1:0]   node_next;

   assign sym_sel  = (state_ff == S_IDLE) ? req_item.symbol : req_ff.symbol;
   assign slot     = CHILD_AW'(cur_ff) * CHILD_AW'(ALPHABET) + CHILD_AW'(sym_sel);
   assign in_range = 32'(req_item.symbol) < 32'(ALPHABET);
   assign walk     = req_item.has_symbol && !(req_item.cmd == ptc_pkg::CMD_ADD && !in_range);

   assign cnt_end   = cnt_rd_data[2*CW-1:CW];
   assign cnt_pass  = cnt_rd_data[CW-1:0];
   assign end_inc   = (cnt_end == {CW{1'b1}}) ? cnt_end : cnt_end + CW'(1);
   assign end_dec   = (cnt_end == '0) ? cnt_end : cnt_end - CW'(1);
   assign pass_inc  = (cnt_pass == {CW{1'b1}}) ? cnt_pass : cnt_pass + CW'(1);
   assign pass_dec  = (cnt_pass == '0) ? cnt_pass : cnt_pass - CW'(1);
   assign count_sel = (req_ff.cmd == ptc_pkg::CMD_COUNT_PREFIX) ? cnt_pass : cnt_end;
   assign count_sat = (32'(count_sel) > 32'(ptc_pkg::OUT_COUNT_MAX)) ?
                      ptc_pkg::OUT_COUNT_MAX : 16'(count_sel);
   assign pool_full = used_ff >= USED_W'(MAX_NODES);

   always_comb begin
      state_in      = state_ff;
      clear_in      = clear_ff;
      req_in        = req_ff;
      cur_in        = cur_ff;
      used_in       = used_ff;
      depth_in      = depth_ff;
      miss_in       = miss_ff;
      pop_in        = pop_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      child_wr_en   = 1'b0;
      child_wr_addr = slot;
      child_wr_data = '0;
      child_rd_addr = slot;
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = cur_ff;
      cnt_wr_data   = cnt_rd_data;
      cnt_rd_addr   = cur_ff;
      stack_wr_en   = 1'b0;
      stack_wr_addr = depth_ff[STACK_AW-1:0];
      node_next     = cur_ff;

      unique case (state_ff)
         S_CLEAR: begin
            child_wr_en   = 1'b1;
            child_wr_addr = clear_ff;
            if (clear_ff < CHILD_AW'(MAX_NODES)) begin
               cnt_wr_en   = 1'b1;
               cnt_wr_addr = clear_ff[NODE_W-1:0];
               cnt_wr_data = '0;
            end
            clear_in = clear_ff + CHILD_AW'(1);
            if (clear_ff == CHILD_AW'(CHILD_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (walk) begin
                  if (depth_ff < DEPTH_W'(MAX_LEN)) begin
                     stack_wr_en = 1'b1;
                  end
                  if (depth_ff <= DEPTH_W'(MAX_LEN)) begin
                     depth_in = depth_ff + DEPTH_W'(1);
                  end
                  if (!miss_ff && !in_range) begin
                     miss_in = 1'b1;
                  end
               end
               if (walk && !miss_ff && in_range) begin
                  state_in = S_WALK;
               end else if (req_item.last) begin
                  state_in = S_LEXEC;
               end
            end
         end

         S_WALK: begin
            if (req_ff.cmd == ptc_pkg::CMD_ADD) begin
               if (child_rd_data == '0) begin
                  if (pool_full) begin
                     miss_in = 1'b1;
                  end else begin
                     node_next     = used_ff[NODE_W-1:0];
                     used_in       = used_ff + USED_W'(1);
                     child_wr_en   = 1'b1;
                     child_wr_data = used_ff[NODE_W-1:0];
                  end
               end else begin
                  node_next = child_rd_data;
               end
               if (!(child_rd_data == '0 && pool_full)) begin
                  cnt_wr_en   = 1'b1;
                  cnt_wr_data = {cnt_end, pass_inc};
               end
            end else begin
               if (child_rd_data == '0) begin
                  miss_in = 1'b1;
               end else begin
                  node_next = child_rd_data;
               end
            end
            cur_in      = node_next;
            cnt_rd_addr = node_next;
            state_in    = req_ff.last ? S_LEXEC : S_IDLE;
         end

         S_LEXEC: begin
            rsp_in.found  = 1'b0;
            rsp_in.count  = '0;
            rsp_in.status = ptc_pkg::STATUS_OK;
            unique case (req_ff.cmd)
               ptc_pkg::CMD_ADD: begin
                  if (miss_ff) begin
                     rsp_in.status = ptc_pkg::STATUS_POOL_FULL;
                  end else begin
                     cnt_wr_en   = 1'b1;
                     cnt_wr_data = {end_inc, cnt_pass};
                  end
               end
               ptc_pkg::CMD_EXISTS: begin
                  rsp_in.found = !miss_ff && cnt_end != '0;
               end
               ptc_pkg::CMD_COUNT_EXACT, ptc_pkg::CMD_COUNT_PREFIX: begin
                  rsp_in.count = miss_ff ? 16'd0 : count_sat;
               end
               ptc_pkg::CMD_REMOVE: begin
                  if (depth_ff > DEPTH_W'(MAX_LEN)) begin
                     rsp_in.status = ptc_pkg::STATUS_TOO_LONG;
                  end else if (!miss_ff && cnt_end != '0) begin
                     cnt_wr_en    = 1'b1;
                     cnt_wr_data  = {end_dec, cnt_pass};
                     rsp_in.found = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (req_ff.cmd == ptc_pkg::CMD_REMOVE && depth_ff <= DEPTH_W'(MAX_LEN) &&
                !miss_ff && cnt_end != '0 && depth_ff != '0) begin
               pop_in   = '0;
               state_in = S_POP_CNT;
            end else begin
               rsp_valid_in = 1'b1;
               cur_in       = '0;
               depth_in     = '0;
               miss_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end

         S_POP_CNT: begin
            cnt_rd_addr = stack_rd_data;
            state_in    = S_POP_WR;
         end

         S_POP_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = stack_rd_data;
            cnt_wr_data = {cnt_end, pass_dec};
            pop_in      = pop_ff + DEPTH_W'(1);
            if (pop_in == depth_ff) begin
               rsp_valid_in = 1'b1;
               cur_in       = '0;
               depth_in     = '0;
               miss_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               state_in = S_POP_CNT;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_ff     <= '0;
         cur_ff       <= '0;
         used_ff      <= USED_W'(1);
         depth_ff     <= '0;
         miss_ff      <= 1'b0;
         pop_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         cur_ff       <= cur_in;
         used_ff      <= used_in;
         depth_ff     <= depth_in;
         miss_ff      <= miss_in;
         pop_ff       <= pop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   ptc_ram #(
      .WIDTH (NODE_W),
      .DEPTH (CHILD_DEPTH)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_addr (child_rd_addr),
      .rd_data (child_rd_data)
   );

   ptc_ram #(
      .WIDTH (2 * CW),
      .DEPTH (MAX_NODES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   ptc_ram #(
      .WIDTH (NODE_W),
      .DEPTH (MAX_LEN)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_wr_en),
      .wr_addr (stack_wr_addr),
      .wr_data (cur_ff),
      .rd_addr (pop_in[STACK_AW-1:0]),
      .rd_data (stack_rd_data)
   );

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[rtl/core/ptc_ram.sv]
module ptc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ptc_checker.sv]
`include "prefix_trie_counter_assert.svh"

module ptc_checker (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_valid,
   input ptc_pkg::rsp_type rsp_item
);

   logic status_ok;
   logic no_count;

   assign status_ok = rsp_item.status == ptc_pkg::STATUS_OK;
   assign no_count  = rsp_item.count == 16'd0;

   `PTC_ASSERT_NOW(a_clear_after_reset, $past(reset), busy, "no clearing pass after reset")
   `PTC_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy, "response while still busy")
   `PTC_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "back to back responses")
   `PTC_ASSERT_NOW(a_status_clean, rsp_valid && !status_ok, !rsp_item.found && no_count, "error with data")
   `PTC_ASSERT_NOW(a_found_no_count, rsp_valid && rsp_item.found, no_count && status_ok, "found with count")

endmodule

bind prefix_trie_counter ptc_checker u_ptc_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
